/* rtl/clld_pkg.sv */
// Shared definitions for the circular doubly linked list manager.
// Request codes, sequencer states and internal operation codes.
// Depends on nothing; imported by circular_linked_list_deque.
package clld_pkg;

    // Request codes carried in the low bits of the request transfer.
    localparam logic [2:0] REQ_PUSH_HEAD = 3'd0;
    localparam logic [2:0] REQ_PUSH_TAIL = 3'd1;
    localparam logic [2:0] REQ_POP_HEAD  = 3'd2;
    localparam logic [2:0] REQ_POP_TAIL  = 3'd3;
    localparam logic [2:0] REQ_REMOVE    = 3'd4;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RD1  = 6'b000010,
        ST_RD2  = 6'b000100,
        ST_WR1  = 6'b001000,
        ST_WR2  = 6'b010000,
        ST_DONE = 6'b100000
    } clld_state_t;

    // Work decided when a request is taken.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_EMPTY,
        OP_PUSH,
        OP_POP_HEAD,
        OP_POP_TAIL,
        OP_REMOVE
    } clld_op_t;

endpackage

/* rtl/clld_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the next and previous link stores; depends on nothing.
module clld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/circular_linked_list_deque.sv */
// Circular doubly linked list manager over a fixed pool of buffer slots.
// Top level; depends on clld_pkg and two clld_ram instances for the links.
//
//   Channel   Direction  Handshake                      Payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  req_type, slot_index
//   m_axis    out        m_axis_tvalid / m_axis_tready  slot_out, found, list_count
//
// Each request is handled alone by a small sequencer around the two link
// memories, each with one write port and a registered read. A push into a
// non-empty list also passes through WR2, as each memory takes two writes,
// and a pop tail passes through RD2 for its dependent read of the old tail.
// Reset clears the head, the count and the handshake state; link entries
// hold nothing until written, and a remove reads the named slot's entries even if never written.
// A result waiting in the output register does not block the next request;
// only the one after it waits until the result transfer completes.
module circular_linked_list_deque
    import clld_pkg::*;
#(
    parameter int POOL_SLOTS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request stream. tdata fields from bit 0: req_type[2:0], slot_index[10:3].
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    // Result stream. tdata fields from bit 0: slot_out[7:0], found[8],
    // list_count[17:9].
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata
);

    localparam int AW = $clog2(POOL_SLOTS);
    localparam int CW = $clog2(POOL_SLOTS + 1);

    // The requested slot is taken modulo the pool size; slot_index has only
    // eight bits, so a constant table does the reduction.
    typedef logic [7:0] slot_tbl_t [256];

    function automatic slot_tbl_t build_slot_tbl();
        slot_tbl_t tbl;
        for (int i = 0; i < 256; i++)
        begin
            tbl[i] = 8'(i % POOL_SLOTS);
        end
        return tbl;
    endfunction

    localparam slot_tbl_t SLOT_TBL = build_slot_tbl();

    // Sequencer and list state.
    clld_state_t   state_reg, state_next;
    clld_op_t      op_reg, op_next;
    logic          push_head_reg, push_head_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;

    // Result being built, then the output register.
    logic [7:0]    res_slot_reg, res_slot_next;
    logic          res_found_reg, res_found_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_slot_reg, out_slot_next;
    logic          out_found_reg, out_found_next;
    logic [8:0]    out_count_reg, out_count_next;

    // Link memory ports.
    logic          next_we, prev_we;
    logic [AW-1:0] next_waddr, prev_waddr;
    logic [AW-1:0] next_wdata, prev_wdata;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] next_rd, prev_rd;

    // Request decode.
    logic [2:0]    req_in;
    logic [7:0]    slot_mod;
    logic [AW-1:0] slot_in;
    logic          accept;
    logic          load_out;
    logic          list_empty;
    logic          list_full;
    logic          last_item;

    assign req_in     = s_axis_tdata[2:0];
    assign slot_mod   = SLOT_TBL[s_axis_tdata[10:3]];
    assign slot_in    = AW'(slot_mod);
    assign list_empty = (count_reg == CW'(0));
    assign list_full  = (count_reg == CW'(POOL_SLOTS));
    assign last_item  = (count_reg == CW'(1));

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign load_out      = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_count_reg, out_found_reg, out_slot_reg};

    clld_ram #(
        .WIDTH (AW),
        .DEPTH (POOL_SLOTS)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (rd_addr),
        .rdata (next_rd)
    );

    clld_ram #(
        .WIDTH (AW),
        .DEPTH (POOL_SLOTS)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (rd_addr),
        .rdata (prev_rd)
    );

    // Read address: the head's links for pushes and pops, the named slot's
    // links for a remove, and the old tail's links in the second read of a
    // pop tail. Read data is used in the cycle after the address.
    always_comb
    begin
        if (state_reg == ST_RD2)
        begin
            rd_addr = prev_rd;
        end
        else if (op_reg == OP_REMOVE)
        begin
            rd_addr = slot_reg;
        end
        else
        begin
            rd_addr = head_reg;
        end
    end

    // Link writes. A push into a non-empty list uses both WR1 and WR2 because each
    // memory takes two writes; an empty push or an unlink writes one entry in each memory.
    always_comb
    begin
        next_we    = 1'b0;
        prev_we    = 1'b0;
        next_waddr = slot_reg;
        next_wdata = slot_reg;
        prev_waddr = slot_reg;
        prev_wdata = slot_reg;
        case (state_reg)
            ST_WR1:
            begin
                case (op_reg)
                    OP_PUSH_EMPTY:
                    begin
                        next_we = 1'b1;
                        prev_we = 1'b1;
                    end
                    OP_PUSH:
                    begin
                        next_we    = 1'b1;
                        next_wdata = head_reg;
                        prev_we    = 1'b1;
                        prev_wdata = prev_rd;
                    end
                    OP_POP_HEAD, OP_POP_TAIL, OP_REMOVE:
                    begin
                        prev_we    = 1'b1;
                        prev_waddr = next_rd;
                        prev_wdata = prev_rd;
                        next_we    = 1'b1;
                        next_waddr = prev_rd;
                        next_wdata = next_rd;
                    end
                    default:
                    begin
                        next_we = 1'b0;
                        prev_we = 1'b0;
                    end
                endcase
            end
            ST_WR2:
            begin
                next_we    = 1'b1;
                next_waddr = tail_reg;
                prev_we    = 1'b1;
                prev_waddr = head_reg;
            end
            default:
            begin
                next_we = 1'b0;
                prev_we = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        push_head_next = push_head_reg;
        slot_next      = slot_reg;
        tail_next      = tail_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        res_slot_next  = res_slot_reg;
        res_found_next = res_found_reg;
        out_slot_next  = out_slot_reg;
        out_found_next = out_found_reg;
        out_count_next = out_count_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    slot_next      = slot_in;
                    push_head_next = (req_in == REQ_PUSH_HEAD);
                    res_slot_next  = 8'd0;
                    res_found_next = 1'b0;
                    op_next        = OP_NONE;
                    case (req_in)
                        REQ_PUSH_HEAD, REQ_PUSH_TAIL:
                        begin
                            res_slot_next = slot_mod;
                            if (list_full)
                            begin
                                op_next = OP_NONE;
                            end
                            else
                            begin
                                res_found_next = 1'b1;
                                op_next = list_empty ? OP_PUSH_EMPTY : OP_PUSH;
                            end
                        end
                        REQ_POP_HEAD, REQ_POP_TAIL:
                        begin
                            if (!list_empty)
                            begin
                                res_slot_next  = 8'(head_reg);
                                res_found_next = 1'b1;
                                op_next = (req_in == REQ_POP_TAIL) ? OP_POP_TAIL
                                                                    : OP_POP_HEAD;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            res_slot_next = slot_mod;
                            if (!list_empty)
                            begin
                                res_found_next = 1'b1;
                                // Removing the head is the same as a pop head.
                                op_next = (slot_in == head_reg) ? OP_POP_HEAD
                                                                : OP_REMOVE;
                            end
                        end
                        default:
                        begin
                            op_next = OP_NONE;
                        end
                    endcase
                    case (op_next)
                        OP_NONE:       state_next = ST_DONE;
                        OP_PUSH_EMPTY: state_next = ST_WR1;
                        default:       state_next = ST_RD1;
                    endcase
                end
            end
            ST_RD1:
            begin
                state_next = (op_reg == OP_POP_TAIL) ? ST_RD2 : ST_WR1;
            end
            ST_RD2:
            begin
                // The old tail is the slot that is taken.
                tail_next     = prev_rd;
                res_slot_next = 8'(prev_rd);
                state_next    = ST_WR1;
            end
            ST_WR1:
            begin
                case (op_reg)
                    OP_PUSH_EMPTY:
                    begin
                        head_next  = slot_reg;
                        count_next = count_reg + CW'(1);
                        state_next = ST_DONE;
                    end
                    OP_PUSH:
                    begin
                        tail_next  = prev_rd;
                        state_next = ST_WR2;
                    end
                    OP_POP_HEAD, OP_POP_TAIL:
                    begin
                        head_next  = last_item ? AW'(0) : next_rd;
                        count_next = count_reg - CW'(1);
                        state_next = ST_DONE;
                    end
                    OP_REMOVE:
                    begin
                        head_next  = last_item ? AW'(0) : head_reg;
                        count_next = count_reg - CW'(1);
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_WR2:
            begin
                if (push_head_reg)
                begin
                    head_next = slot_reg;
                end
                count_next = count_reg + CW'(1);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_slot_next  = res_slot_reg;
                    out_found_next = res_found_reg;
                    out_count_next = 9'(count_reg);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_NONE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        push_head_reg <= push_head_next;
        slot_reg      <= slot_next;
        tail_reg      <= tail_next;
        res_slot_reg  <= res_slot_next;
        res_found_reg <= res_found_next;
        out_slot_reg  <= out_slot_next;
        out_found_reg <= out_found_next;
        out_count_reg <= out_count_next;
    end

    // The count never passes the pool size.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(POOL_SLOTS))
    else $error("list count exceeds pool size");

    // An empty list always has its head back at slot zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        list_empty |-> (head_reg == AW'(0)))
    else $error("empty list with nonzero head");

    // Link writes happen only in the write states of the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (next_we || prev_we) |-> ((state_reg == ST_WR1) || (state_reg == ST_WR2)))
    else $error("link write outside a write state");

    // A finished request always shows up on the result stream.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (m_axis_tvalid && (m_axis_tdata[7:0] == $past(res_slot_reg))))
    else $error("finished result not presented");

endmodule
